// ===== rtl/core/hts_pkg.sv =====
package hts_pkg;

	// Output limit and reset value of the capacity register
	localparam logic [12:0] OUT_LIMIT = 13'd4096;
	localparam logic [12:0] CAP_RESET = 13'd256;

	// Number of recognised entities and longest entity text
	localparam int ENT_NUM = 6;
	localparam int BUF_DEPTH = 6;

	// Byte codes with a meaning of their own
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN
	} state_t;

	// Datapath operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_FEED_IN,
		OP_FEED_REPLAY,
		OP_FLUSH,
		OP_TERM
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic rcnt_zero;
		logic fill_zero;
		logic eot;
		logic replay_next;
	} status_t;

	// Entity text, left aligned, six bytes
	function automatic logic [47:0] ent_text(input logic [2:0] e);
		logic [47:0] s;
		unique case (e)
			3'd0:    s = {"&amp;", 8'h00};
			3'd1:    s = {"&lt;", 16'h0000};
			3'd2:    s = {"&gt;", 16'h0000};
			3'd3:    s = "&quot;";
			3'd4:    s = {"&#39;", 8'h00};
			3'd5:    s = "&nbsp;";
			default: s = '0;
		endcase
		return s;
	endfunction

	// Byte at position pos of entity e
	function automatic logic [7:0] ent_char(input logic [2:0] e, input logic [2:0] pos);
		logic [47:0] sh;
		logic [7:0]  c;
		sh = ent_text(e) >> {3'd5 - pos, 3'b000};
		c = (pos > 3'd5) ? 8'h00 : sh[7:0];
		return c;
	endfunction

	function automatic logic [2:0] ent_len(input logic [2:0] e);
		logic [2:0] n;
		unique case (e)
			3'd0:    n = 3'd5;
			3'd1:    n = 3'd4;
			3'd2:    n = 3'd4;
			3'd3:    n = 3'd6;
			3'd4:    n = 3'd5;
			3'd5:    n = 3'd6;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] ent_val(input logic [2:0] e);
		logic [7:0] v;
		unique case (e)
			3'd0:    v = CH_AMP;
			3'd1:    v = CH_LT;
			3'd2:    v = CH_GT;
			3'd3:    v = CH_QUOT;
			3'd4:    v = CH_APOS;
			3'd5:    v = CH_SPACE;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/hts_datapath.sv =====
module hts_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  hts_pkg::cmd_t       cmd,
	output hts_pkg::status_t    status,
	input  logic [7:0]          in_byte,
	input  logic                in_eot,
	input  logic                cfg_wr_en,
	input  logic [12:0]         cfg_wr_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [11:0]         out_spaces,
	output logic [7:0]          out_char,
	output logic                out_char_valid,
	output logic                out_last
);

	// Request and document state
	logic [7:0]  in_q;
	logic        eot_q;
	logic [12:0] cap_q;
	logic        inside_q, los_q, full_q;
	logic [11:0] held_q, wc_q;
	logic [2:0]  fill_q, rcnt_q;
	logic [5:0]  cand_q;
	logic [7:0]  buf_q [hts_pkg::BUF_DEPTH];

	// Output register
	logic        ovalid_q;
	logic [11:0] osp_q;
	logic [7:0]  ochar_q;
	logic        ocv_q, olast_q;

	// Next values
	logic        inside_d, los_d, full_d;
	logic [11:0] held_d, wc_d;
	logic [2:0]  fill_d, rcnt_d;
	logic [5:0]  cand_d, newcand;
	logic [7:0]  buf_d [hts_pkg::BUF_DEPTH];
	logic [7:0]  buf_w [hts_pkg::BUF_DEPTH];

	logic        slot_free, is_rep, do_emit, do_space, shift, full_hit;
	logic        space_ev, char_ev, res_valid, res_cv, res_last;
	logic        any_cand, any_done;
	logic [7:0]  x, buf_rd, emit_c, done_val, res_char;
	logic [11:0] res_sp;
	logic [12:0] cap_eff, wc_inc;

	assign slot_free = !ovalid_q || out_ready;
	assign is_rep    = (cmd.op == hts_pkg::OP_FEED_REPLAY);
	assign cap_eff   = (cap_q > hts_pkg::OUT_LIMIT) ? hts_pkg::OUT_LIMIT : cap_q;
	assign wc_inc    = {1'b0, wc_q} + 13'd1;
	assign full_hit  = full_q || (wc_inc >= cap_eff);

	// Byte under the replay pointer
	always_comb begin
		buf_rd = 8'h00;
		for (int i = 0; i < hts_pkg::BUF_DEPTH; i++) begin
			if (fill_q == 3'(i)) buf_rd = buf_q[i];
		end
	end

	assign x = is_rep ? buf_rd : in_q;

	// Entity candidates after this byte
	always_comb begin
		any_cand = 1'b0;
		any_done = 1'b0;
		done_val = 8'h00;
		for (int e = 0; e < hts_pkg::ENT_NUM; e++) begin
			newcand[e] = cand_q[e] && (fill_q < hts_pkg::ent_len(3'(e)))
				&& (x == hts_pkg::ent_char(3'(e), fill_q));
			if (newcand[e]) any_cand = 1'b1;
			if (newcand[e] && ((fill_q + 3'd1) == hts_pkg::ent_len(3'(e)))) begin
				any_done = 1'b1;
				done_val = hts_pkg::ent_val(3'(e));
			end
		end
	end

	// One processing step
	always_comb begin
		inside_d = inside_q;
		full_d   = full_q;
		fill_d   = fill_q;
		rcnt_d   = rcnt_q;
		cand_d   = cand_q;
		do_emit  = 1'b0;
		do_space = 1'b0;
		emit_c   = 8'h00;
		shift    = 1'b0;
		unique case (cmd.op)
			hts_pkg::OP_FEED_IN, hts_pkg::OP_FEED_REPLAY: begin
				if (is_rep) rcnt_d = rcnt_q - 3'd1;
				if (fill_q != 3'd0) begin
					if (any_done) begin
						fill_d  = 3'd0;
						do_emit = 1'b1;
						emit_c  = done_val;
					end else if (any_cand) begin
						fill_d = fill_q + 3'd1;
						cand_d = newcand;
					end else begin
						// no entity: emit the ampersand, replay what follows it
						do_emit = 1'b1;
						emit_c  = hts_pkg::CH_AMP;
						fill_d  = 3'd0;
						shift   = 1'b1;
						rcnt_d  = 3'(fill_q + (is_rep ? rcnt_q - 3'd1 : rcnt_q));
					end
				end else begin
					if (full_hit) begin
						full_d = 1'b1;
					end else if (x == hts_pkg::CH_LT) begin
						inside_d = 1'b1;
					end else if (x == hts_pkg::CH_GT) begin
						inside_d = 1'b0;
						do_space = 1'b1;
					end else if (inside_q) begin
						do_space = 1'b0;
					end else if (x == hts_pkg::CH_AMP) begin
						fill_d = 3'd1;
						cand_d = '1;
					end else if (x == hts_pkg::CH_CR || x == hts_pkg::CH_LF
							|| x == hts_pkg::CH_TAB) begin
						do_space = 1'b1;
					end else begin
						do_emit = 1'b1;
						emit_c  = x;
					end
					if (is_rep && fill_d == 3'd0) shift = 1'b1;
				end
			end
			hts_pkg::OP_FLUSH: begin
				do_emit = 1'b1;
				emit_c  = hts_pkg::CH_AMP;
				fill_d  = 3'd0;
				shift   = 1'b1;
				rcnt_d  = 3'(rcnt_q + fill_q - 3'd1);
			end
			default: begin
				fill_d = fill_q;
			end
		endcase
	end

	// Space and character accounting
	always_comb begin
		space_ev = (do_space && wc_q != 12'd0 && !los_q)
			|| (do_emit && emit_c == hts_pkg::CH_SPACE);
		char_ev  = do_emit && emit_c != hts_pkg::CH_SPACE;
		held_d   = held_q;
		wc_d     = wc_q;
		los_d    = los_q;
		if (space_ev) begin
			held_d = held_q + 12'd1;
			wc_d   = wc_q + 12'd1;
			los_d  = 1'b1;
		end else if (char_ev) begin
			held_d = 12'd0;
			wc_d   = wc_q + 12'd1;
			los_d  = 1'b0;
		end
	end

	// Result of this step
	always_comb begin
		res_valid = char_ev || (cmd.op == hts_pkg::OP_TERM);
		res_sp    = (cmd.op == hts_pkg::OP_TERM) ? 12'd0 : held_q;
		res_char  = (cmd.op == hts_pkg::OP_TERM) ? 8'h00 : emit_c;
		res_cv    = (cmd.op != hts_pkg::OP_TERM);
		res_last  = (cmd.op == hts_pkg::OP_TERM);
	end

	// Entity buffer: write the new byte, then drop the head on a shift
	always_comb begin
		for (int i = 0; i < hts_pkg::BUF_DEPTH; i++) begin
			buf_w[i] = (cmd.op == hts_pkg::OP_FEED_IN && fill_q == 3'(i)) ? in_q : buf_q[i];
		end
		for (int i = 0; i < hts_pkg::BUF_DEPTH - 1; i++) begin
			buf_d[i] = shift ? buf_w[i + 1] : buf_w[i];
		end
		buf_d[hts_pkg::BUF_DEPTH - 1] = buf_w[hts_pkg::BUF_DEPTH - 1];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= hts_pkg::CAP_RESET;
			eot_q    <= 1'b0;
			inside_q <= 1'b0;
			los_q    <= 1'b0;
			full_q   <= 1'b0;
			held_q   <= 12'd0;
			wc_q     <= 12'd0;
			fill_q   <= 3'd0;
			rcnt_q   <= 3'd0;
			cand_q   <= 6'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) cap_q <= cfg_wr_data;
			if (cmd.op == hts_pkg::OP_LOAD) eot_q <= in_eot;
			if (slot_free) ovalid_q <= res_valid;
			if (cmd.op == hts_pkg::OP_TERM) begin
				inside_q <= 1'b0;
				los_q    <= 1'b0;
				full_q   <= 1'b0;
				held_q   <= 12'd0;
				wc_q     <= 12'd0;
				fill_q   <= 3'd0;
				rcnt_q   <= 3'd0;
				cand_q   <= 6'd0;
			end else begin
				inside_q <= inside_d;
				los_q    <= los_d;
				full_q   <= full_d;
				held_q   <= held_d;
				wc_q     <= wc_d;
				fill_q   <= fill_d;
				rcnt_q   <= rcnt_d;
				cand_q   <= cand_d;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == hts_pkg::OP_LOAD) in_q <= in_byte;
		for (int i = 0; i < hts_pkg::BUF_DEPTH; i++) buf_q[i] <= buf_d[i];
		if (slot_free && res_valid) begin
			osp_q   <= res_sp;
			ochar_q <= res_char;
			ocv_q   <= res_cv;
			olast_q <= res_last;
		end
	end

	assign status.slot_free   = slot_free;
	assign status.rcnt_zero   = (rcnt_q == 3'd0);
	assign status.fill_zero   = (fill_q == 3'd0);
	assign status.eot         = eot_q;
	assign status.replay_next = (rcnt_d != 3'd0);

	assign out_valid      = ovalid_q;
	assign out_spaces     = osp_q;
	assign out_char       = ochar_q;
	assign out_char_valid = ocv_q;
	assign out_last       = olast_q;

endmodule

// ===== rtl/core/hts_ctrl.sv =====
module hts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hts_pkg::status_t  status,
	output hts_pkg::cmd_t     cmd
);

	hts_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= hts_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hts_pkg::ST_IDLE: begin
				if (in_valid) state_d = hts_pkg::ST_FEED;
			end
			hts_pkg::ST_FEED: begin
				if (status.slot_free) begin
					state_d = (status.replay_next || status.eot) ? hts_pkg::ST_DRAIN
						: hts_pkg::ST_IDLE;
				end
			end
			hts_pkg::ST_DRAIN: begin
				if (!status.rcnt_zero || (status.eot && !status.fill_zero)) begin
					state_d = hts_pkg::ST_DRAIN;
				end else if (status.eot) begin
					if (status.slot_free) state_d = hts_pkg::ST_IDLE;
				end else begin
					state_d = hts_pkg::ST_IDLE;
				end
			end
			default: state_d = hts_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready = 1'b0;
		cmd.op   = hts_pkg::OP_NONE;
		unique case (state_q)
			hts_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = hts_pkg::OP_LOAD;
			end
			hts_pkg::ST_FEED: begin
				if (status.slot_free) cmd.op = hts_pkg::OP_FEED_IN;
			end
			hts_pkg::ST_DRAIN: begin
				if (status.slot_free) begin
					if (!status.rcnt_zero)                    cmd.op = hts_pkg::OP_FEED_REPLAY;
					else if (status.eot && !status.fill_zero) cmd.op = hts_pkg::OP_FLUSH;
					else if (status.eot)                      cmd.op = hts_pkg::OP_TERM;
				end
			end
			default: cmd.op = hts_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== rtl/core/html_tag_stripper.sv =====
// HTML to plain text filter. Raw bytes come in on the slave stream, tlast on
// the final byte of a document. Tags are dropped, the six common entities are
// decoded, and '>', CR, LF and tab become single spaces. Spaces are not sent
// on their own: each output request carries the count of spaces that precede
// its character, so trailing spaces disappear. The last request of a document
// is a terminator with char_valid (tuser) low and tlast high. Output stops at
// capacity minus one bytes, spaces included; capacity is set through the
// write port (reset 256, values over 4096 act as 4096). A byte is captured,
// then passes once through the byte processor. A failed entity match
// replays the bytes held behind the '&', up to five, then returns to idle;
// at end of document an open entity is flushed (its '&' sent, the rest
// replayed) before the terminator is sent. Every processing step waits
// while the single output register holds a request not yet taken.
module html_tag_stripper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [12:0] cfg_wr_data,   // out_capacity
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tlast,  // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [11:0] spaces_before, [19:12] out_char, zero pad
	output logic        m_axis_tuser,  // [0] char_valid
	output logic        m_axis_tlast   // last_result
);

	hts_pkg::cmd_t    cmd;
	hts_pkg::status_t status;
	logic [11:0]      spaces;
	logic [7:0]       ochar;

	hts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	hts_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_byte        (s_axis_tdata),
		.in_eot         (s_axis_tlast),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_spaces     (spaces),
		.out_char       (ochar),
		.out_char_valid (m_axis_tuser),
		.out_last       (m_axis_tlast)
	);

	assign m_axis_tdata = {4'h0, ochar, spaces};

endmodule
